>>> sv/hvm_pkg.sv
// hvm_pkg: types, codes and limits shared by the air-conditioner register map
// no dependencies; the design files refer to it by scoped names, the testbench files import it
package hvm_pkg;

    // number of items one request can carry in register form
    localparam int LANES = 4;
    // coil write lanes and read bit positions
    localparam int COIL_LANES = 2;
    localparam int READ_BITS  = 3;

    // access kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
    localparam logic [7:0] FC_RW_REGS       = 8'd23;

    // exception codes
    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_FUNCTION = 2'd1;
    localparam logic [1:0] EXC_ADDRESS  = 2'd2;
    localparam logic [1:0] EXC_VALUE    = 2'd3;

    // holding register offsets
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_TEMP  = 2'd1;
    localparam logic [1:0] REG_TIMER = 2'd2;
    localparam logic [1:0] REG_FAN   = 2'd3;

    // coil offsets and single-coil codes
    localparam logic        COIL_POWER = 1'b0;
    localparam logic        COIL_SWING = 1'b1;
    localparam logic [15:0] COIL_ON    = 16'hFF00;
    localparam logic [15:0] COIL_OFF   = 16'h0000;

    // highest offsets of each table, lane offsets saturate at IDX_SAT
    localparam logic [2:0] REG_LAST  = 3'd3;
    localparam logic [2:0] COIL_LAST = 3'd1;
    localparam logic [2:0] DISC_LAST = 3'd2;
    localparam logic [2:0] IDX_SAT   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  function_code;
        logic [15:0] address;
        logic [10:0] count;
        logic [15:0] value0;
        logic [15:0] value1;
        logic [15:0] value2;
        logic [15:0] value3;
        logic [1:0]  coil_bits;
        logic [2:0]  device_status;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  exception;
        logic [15:0] read_word0;
        logic [15:0] read_word1;
        logic [15:0] read_word2;
        logic [15:0] read_word3;
        logic [2:0]  read_bits;
    } out_item_t;

    // one unit's stored registers and coils
    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] temp;
        logic [5:0] timer;
        logic [1:0] fan;
        logic       power;
        logic       swing;
    } unit_rec_t;

    // what one lane is told about its item
    typedef struct packed {
        logic        active;
        logic [2:0]  idx;
        logic [15:0] value;
    } lane_in_t;

    // what one lane found
    typedef struct packed {
        logic        active;
        logic        reg_ok;
        logic        coil_ok;
        logic        disc_ok;
        logic        val_ok;
        logic [1:0]  reg_sel;
        logic        coil_sel;
        logic [15:0] word;
        logic        coil_bit;
        logic        disc_bit;
    } lane_out_t;

    // store write request
    typedef struct packed {
        logic      we;
        unit_rec_t rec;
    } store_upd_t;

    // upper limit of each holding register
    function automatic logic [15:0] reg_limit(input logic [1:0] sel);
        logic [15:0] lim;
        case (sel)
            REG_MODE:  lim = 16'd4;
            REG_TEMP:  lim = 16'd14;
            REG_TIMER: lim = 16'd34;
            default:   lim = 16'd3;
        endcase
        return lim;
    endfunction

endpackage

>>> sv/hvac_register_map.sv
// hvac_register_map: register map for a bank of air-conditioner units
// uses hvm_pkg, hvm_store, hvm_lane and hvm_merge
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  request | in_valid / in_ready  | in_item  (hvm_pkg::in_item_t)
//  result  | out_valid / out_ready| out_item (hvm_pkg::out_item_t)
//
// an item's result is built in order once the item is accepted: the unit
// number is worked out on acceptance, the unit record is read from the store
// in the next cycle, and four lanes check and merge in the cycle after, when
// the store and the result register are written unless the result stalls.
// the next item is taken in that last cycle, never during the store read.
// reset clears the valid flags of the store, so all units read zero at once.
// a stalled result holds the last stage and with it the request side.
module hvac_register_map #(
    parameter int UNIT_COUNT  = 8,
    parameter int UNIT_STRIDE = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hvm_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hvm_pkg::out_item_t  out_item
);

    // unit number by reciprocal multiply, exact for every 16-bit address
    localparam int SW    = $clog2(UNIT_STRIDE);
    localparam int SHIFT = 16 + SW;
    localparam int MULT  = ((1 << SHIFT) + UNIT_STRIDE - 1) / UNIT_STRIDE;
    localparam int MW    = $clog2(MULT + 1);
    localparam int PW    = 16 + MW;
    localparam int QW    = $clog2(65535 / UNIT_STRIDE + 1);
    localparam int OW    = (SW < 2) ? 2 : SW;
    localparam int UW    = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    hvm_pkg::state_t state_reg, state_next;

    hvm_pkg::in_item_t  item_reg;
    logic [QW-1:0]      quot_reg;
    logic               unit_ok_reg;
    logic [OW-1:0]      off_reg;
    hvm_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;

    logic               in_fire;
    logic               exec_fire;
    logic               out_free;
    logic [PW-1:0]      prod;
    logic [QW-1:0]      quot;
    logic [15:0]        unit_base;
    logic [15:0]        off_full;
    logic [UW-1:0]      unit_addr;

    hvm_pkg::unit_rec_t                      cur_rec;
    hvm_pkg::lane_in_t  [hvm_pkg::LANES-1:0] lane_in;
    hvm_pkg::lane_out_t [hvm_pkg::LANES-1:0] lane_out;
    hvm_pkg::out_item_t                      result;
    hvm_pkg::store_upd_t                     upd;

    // handshake and stage control
    assign out_free  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            hvm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            hvm_pkg::ST_EXEC:
            begin
                in_ready  = out_free;
                exec_fire = out_free;
            end
            default:
            begin
                in_ready  = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hvm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = hvm_pkg::ST_READ;
                end
            end
            hvm_pkg::ST_READ:
            begin
                state_next = hvm_pkg::ST_EXEC;
            end
            hvm_pkg::ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = in_fire ? hvm_pkg::ST_READ : hvm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hvm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hvm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // unit number of the incoming item
    assign prod = PW'(in_item.address) * PW'(MULT);
    assign quot = QW'(prod >> SHIFT);

    // capture stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg    <= in_item;
            quot_reg    <= quot;
            unit_ok_reg <= 32'(quot) < UNIT_COUNT;
        end
    end

    // register offset within the unit
    assign unit_base = 16'(quot_reg) * 16'(UNIT_STRIDE);
    assign off_full  = item_reg.address - unit_base;

    always_ff @(posedge clk)
    begin
        if (state_reg == hvm_pkg::ST_READ)
        begin
            off_reg <= OW'(off_full);
        end
    end

    assign unit_addr = unit_ok_reg ? UW'(quot_reg) : '0;

    hvm_store #(
        .UNIT_COUNT (UNIT_COUNT),
        .ADDR_W     (UW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == hvm_pkg::ST_READ),
        .rd_addr (unit_addr),
        .rd_rec  (cur_rec),
        .wr_en   (exec_fire && upd.we),
        .wr_addr (unit_addr),
        .wr_rec  (upd.rec)
    );

    // one lane per item slot
    for (genvar k = 0; k < hvm_pkg::LANES; k++)
    begin : g_lane
        logic [OW:0] idx_full;

        assign idx_full = {1'b0, off_reg} + (OW + 1)'(k);

        always_comb
        begin
            lane_in[k].active = item_reg.count > 11'(k);
            lane_in[k].idx    = (idx_full > (OW + 1)'(hvm_pkg::IDX_SAT))
                                ? hvm_pkg::IDX_SAT : idx_full[2:0];
            case (k)
                0:       lane_in[k].value = item_reg.value0;
                1:       lane_in[k].value = item_reg.value1;
                2:       lane_in[k].value = item_reg.value2;
                default: lane_in[k].value = item_reg.value3;
            endcase
        end

        hvm_lane u_lane (
            .lane_in  (lane_in[k]),
            .rec      (cur_rec),
            .status   (item_reg.device_status),
            .lane_out (lane_out[k])
        );
    end

    hvm_merge u_merge (
        .item    (item_reg),
        .unit_ok (unit_ok_reg),
        .cur_rec (cur_rec),
        .lanes   (lane_out),
        .result  (result),
        .upd     (upd)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> sv/hvm_store.sv
// hvm_store: per-unit record memory with one read and one write port
// valid bits in flip-flops make never-written units read as zero; uses hvm_pkg
module hvm_store #(
    parameter int UNIT_COUNT = 8,
    parameter int ADDR_W     = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output hvm_pkg::unit_rec_t rd_rec,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  hvm_pkg::unit_rec_t wr_rec
);

    hvm_pkg::unit_rec_t mem [UNIT_COUNT];
    hvm_pkg::unit_rec_t data_reg;
    logic [UNIT_COUNT-1:0] valid_reg;
    logic                  hit_reg;

    // record array and registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten units read as reset value
    assign rd_rec = hit_reg ? data_reg : '0;

endmodule

>>> sv/hvm_lane.sv
// hvm_lane: checks and reads for one item of a request
// address range, value limit and read data of one offset; uses hvm_pkg
module hvm_lane (
    input  hvm_pkg::lane_in_t  lane_in,
    input  hvm_pkg::unit_rec_t rec,
    input  logic [2:0]         status,
    output hvm_pkg::lane_out_t lane_out
);

    logic [1:0]  sel;
    logic [15:0] word;
    logic        disc;

    assign sel = lane_in.idx[1:0];

    // holding register read
    always_comb
    begin
        case (sel)
            hvm_pkg::REG_MODE:  word = {13'd0, rec.mode};
            hvm_pkg::REG_TEMP:  word = {12'd0, rec.temp};
            hvm_pkg::REG_TIMER: word = {10'd0, rec.timer};
            default:            word = {14'd0, rec.fan};
        endcase
    end

    // live status bit
    always_comb
    begin
        case (sel)
            2'd0:    disc = status[0];
            2'd1:    disc = status[1];
            2'd2:    disc = status[2];
            default: disc = 1'b0;
        endcase
    end

    // range checks and results
    always_comb
    begin
        lane_out.active   = lane_in.active;
        lane_out.reg_ok   = lane_in.idx <= hvm_pkg::REG_LAST;
        lane_out.coil_ok  = lane_in.idx <= hvm_pkg::COIL_LAST;
        lane_out.disc_ok  = lane_in.idx <= hvm_pkg::DISC_LAST;
        lane_out.val_ok   = lane_in.value <= hvm_pkg::reg_limit(sel);
        lane_out.reg_sel  = sel;
        lane_out.coil_sel = lane_in.idx[0];
        lane_out.word     = word;
        lane_out.coil_bit = lane_in.idx[0] ? rec.swing : rec.power;
        lane_out.disc_bit = disc;
    end

endmodule

>>> sv/hvm_merge.sv
// hvm_merge: combines the lane findings into one result and a store update
// first failing item decides the exception; uses hvm_pkg
module hvm_merge (
    input  hvm_pkg::in_item_t                       item,
    input  logic                                    unit_ok,
    input  hvm_pkg::unit_rec_t                      cur_rec,
    input  hvm_pkg::lane_out_t [hvm_pkg::LANES-1:0] lanes,
    output hvm_pkg::out_item_t                      result,
    output hvm_pkg::store_upd_t                     upd
);

    logic [1:0]  exc;
    logic        done;
    logic        over;
    logic        coil_val_ok;
    logic [15:0] words [hvm_pkg::LANES];
    logic [15:0] vals [hvm_pkg::LANES];
    logic [2:0]  bits;

    assign over = item.count > 11'(hvm_pkg::LANES);
    assign coil_val_ok = (item.value0 == hvm_pkg::COIL_ON) ||
                         (item.value0 == hvm_pkg::COIL_OFF);

    // write value carried by each item
    always_comb
    begin
        vals[0] = item.value0;
        vals[1] = item.value1;
        vals[2] = item.value2;
        vals[3] = item.value3;
    end

    // exception, items in order
    always_comb
    begin
        exc  = hvm_pkg::EXC_NONE;
        done = 1'b0;
        if (!unit_ok)
        begin
            exc = hvm_pkg::EXC_ADDRESS;
        end
        else if (item.action == hvm_pkg::ACT_WRITE)
        begin
            case (item.function_code)
                hvm_pkg::FC_WRITE_REG, hvm_pkg::FC_WRITE_REGS, hvm_pkg::FC_RW_REGS:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        if (!done && lanes[k].active)
                        begin
                            if (!lanes[k].reg_ok)
                            begin
                                exc  = hvm_pkg::EXC_ADDRESS;
                                done = 1'b1;
                            end
                            else if (!lanes[k].val_ok)
                            begin
                                exc  = hvm_pkg::EXC_VALUE;
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done && over)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                hvm_pkg::FC_WRITE_COIL:
                begin
                    if (!coil_val_ok)
                    begin
                        exc = hvm_pkg::EXC_VALUE;
                    end
                    else if (!lanes[0].coil_ok)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                hvm_pkg::FC_WRITE_COILS:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        if (lanes[k].active && !lanes[k].coil_ok)
                        begin
                            exc = hvm_pkg::EXC_ADDRESS;
                        end
                    end
                    if (over)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                default:
                begin
                    exc = hvm_pkg::EXC_FUNCTION;
                end
            endcase
        end
        else
        begin
            case (item.function_code)
                hvm_pkg::FC_READ_HOLDING, hvm_pkg::FC_RW_REGS:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        if (lanes[k].active && !lanes[k].reg_ok)
                        begin
                            exc = hvm_pkg::EXC_ADDRESS;
                        end
                    end
                    if (over)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                hvm_pkg::FC_READ_COILS:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        if (lanes[k].active && !lanes[k].coil_ok)
                        begin
                            exc = hvm_pkg::EXC_ADDRESS;
                        end
                    end
                    if (over)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                hvm_pkg::FC_READ_DISCRETE:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        if (lanes[k].active && !lanes[k].disc_ok)
                        begin
                            exc = hvm_pkg::EXC_ADDRESS;
                        end
                    end
                    if (over)
                    begin
                        exc = hvm_pkg::EXC_ADDRESS;
                    end
                end
                default:
                begin
                    exc = hvm_pkg::EXC_FUNCTION;
                end
            endcase
        end
    end

    // read data, zero unless a clean read
    always_comb
    begin
        for (int k = 0; k < hvm_pkg::LANES; k++)
        begin
            words[k] = '0;
        end
        bits = '0;
        if (exc == hvm_pkg::EXC_NONE && item.action == hvm_pkg::ACT_READ)
        begin
            case (item.function_code)
                hvm_pkg::FC_READ_HOLDING, hvm_pkg::FC_RW_REGS:
                begin
                    for (int k = 0; k < hvm_pkg::LANES; k++)
                    begin
                        words[k] = lanes[k].active ? lanes[k].word : 16'd0;
                    end
                end
                hvm_pkg::FC_READ_COILS:
                begin
                    for (int k = 0; k < hvm_pkg::READ_BITS; k++)
                    begin
                        bits[k] = lanes[k].active & lanes[k].coil_bit;
                    end
                end
                hvm_pkg::FC_READ_DISCRETE:
                begin
                    for (int k = 0; k < hvm_pkg::READ_BITS; k++)
                    begin
                        bits[k] = lanes[k].active & lanes[k].disc_bit;
                    end
                end
                default:
                begin
                    bits = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        result.exception  = exc;
        result.read_word0 = words[0];
        result.read_word1 = words[1];
        result.read_word2 = words[2];
        result.read_word3 = words[3];
        result.read_bits  = bits;
    end

    // store update: registers all or nothing, coils up to the bad address
    always_comb
    begin
        upd.we  = 1'b0;
        upd.rec = cur_rec;
        if (unit_ok && item.action == hvm_pkg::ACT_WRITE)
        begin
            case (item.function_code)
                hvm_pkg::FC_WRITE_REG, hvm_pkg::FC_WRITE_REGS, hvm_pkg::FC_RW_REGS:
                begin
                    if (exc == hvm_pkg::EXC_NONE)
                    begin
                        upd.we = 1'b1;
                        for (int k = 0; k < hvm_pkg::LANES; k++)
                        begin
                            if (lanes[k].active)
                            begin
                                case (lanes[k].reg_sel)
                                    hvm_pkg::REG_MODE:
                                        upd.rec.mode = vals[k][2:0];
                                    hvm_pkg::REG_TEMP:
                                        upd.rec.temp = vals[k][3:0];
                                    hvm_pkg::REG_TIMER:
                                        upd.rec.timer = vals[k][5:0];
                                    default:
                                        upd.rec.fan = vals[k][1:0];
                                endcase
                            end
                        end
                    end
                end
                hvm_pkg::FC_WRITE_COIL:
                begin
                    if (exc == hvm_pkg::EXC_NONE)
                    begin
                        upd.we = 1'b1;
                        if (lanes[0].coil_sel == hvm_pkg::COIL_SWING)
                        begin
                            upd.rec.swing = item.value0 == hvm_pkg::COIL_ON;
                        end
                        else
                        begin
                            upd.rec.power = item.value0 == hvm_pkg::COIL_ON;
                        end
                    end
                end
                hvm_pkg::FC_WRITE_COILS:
                begin
                    upd.we = 1'b1;
                    for (int k = 0; k < hvm_pkg::COIL_LANES; k++)
                    begin
                        if (lanes[k].active && lanes[k].coil_ok)
                        begin
                            if (lanes[k].coil_sel == hvm_pkg::COIL_POWER)
                            begin
                                upd.rec.power = item.coil_bits[k];
                            end
                            else
                            begin
                                upd.rec.swing = item.coil_bits[k];
                            end
                        end
                    end
                end
                default:
                begin
                    upd.we = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> tb/hvm_tracker_pkg.sv
// hvm_tracker_pkg: scoreboard for the air-conditioner register map testbench
// depends on hvm_pkg for the item types and the function and exception codes
package hvm_tracker_pkg;

    import hvm_pkg::*;

    localparam int MAP_UNITS  = 8;
    localparam int MAP_STRIDE = 16;

    // upper limit of each holding register
    localparam int unsigned MODE_MAX  = 4;
    localparam int unsigned TEMP_MAX  = 14;
    localparam int unsigned TIMER_MAX = 34;
    localparam int unsigned FAN_MAX   = 3;

    // limit of a holding register offset, zero past the table
    function automatic int unsigned reg_ceiling(int unsigned idx);
        int unsigned lim;
        if (idx > REG_LAST)
            lim = 0;
        else
        begin
            case (2'(idx))
                REG_MODE:  lim = MODE_MAX;
                REG_TEMP:  lim = TEMP_MAX;
                REG_TIMER: lim = TIMER_MAX;
                default:   lim = FAN_MAX;
            endcase
        end
        return lim;
    endfunction

    class unit_map_tracker;

        unit_rec_t   units [MAP_UNITS];
        out_item_t   replies_due [$];
        int unsigned faults;

        function new();
            foreach (units[u])
                units[u] = '0;
            faults = 0;
        endfunction

        // commit one holding register
        function void store_word(int unsigned u, int unsigned idx, logic [15:0] v);
            case (2'(idx))
                REG_MODE:  units[u].mode  = v[2:0];
                REG_TEMP:  units[u].temp  = v[3:0];
                REG_TIMER: units[u].timer = v[5:0];
                default:   units[u].fan   = v[1:0];
            endcase
        endfunction

        function logic [15:0] fetch_word(int unsigned u, int unsigned idx);
            logic [15:0] w;
            case (2'(idx))
                REG_MODE:  w = 16'(units[u].mode);
                REG_TEMP:  w = 16'(units[u].temp);
                REG_TIMER: w = 16'(units[u].timer);
                default:   w = 16'(units[u].fan);
            endcase
            return w;
        endfunction

        function void store_coil(int unsigned u, int unsigned idx, logic v);
            if (idx == 0)
                units[u].power = v;
            else
                units[u].swing = v;
        endfunction

        // works out the reply to one request and updates the unit store
        function out_item_t apply_request(in_item_t it);
            out_item_t   r;
            int unsigned u;
            int unsigned off;
            int unsigned idx;
            int unsigned k;
            int unsigned cnt;
            logic [15:0] vals [4];
            logic [15:0] words [4];
            logic [2:0]  bits;
            logic [1:0]  exc;
            logic        cv;
            u   = it.address / MAP_STRIDE;
            off = it.address % MAP_STRIDE;
            cnt = it.count;
            vals[0] = it.value0;
            vals[1] = it.value1;
            vals[2] = it.value2;
            vals[3] = it.value3;
            foreach (words[j])
                words[j] = '0;
            bits = '0;
            exc  = EXC_NONE;
            cv   = 1'b0;
            if (u >= MAP_UNITS)
                exc = EXC_ADDRESS;
            else if (it.action == ACT_WRITE)
            begin
                case (it.function_code)
                    FC_WRITE_REG, FC_WRITE_REGS, FC_RW_REGS:
                    begin
                        // every item checked in order before anything commits
                        for (k = 0; k < cnt && exc == EXC_NONE; k++)
                        begin
                            idx = off + k;
                            if (idx > REG_LAST)
                                exc = EXC_ADDRESS;
                            else if (vals[k] > reg_ceiling(idx))
                                exc = EXC_VALUE;
                        end
                        if (exc == EXC_NONE)
                            for (k = 0; k < cnt; k++)
                                store_word(u, off + k, vals[k]);
                    end
                    FC_WRITE_COIL:
                    begin
                        // value checked before the coil address, count ignored
                        if (vals[0] == COIL_ON)
                            cv = 1'b1;
                        else if (vals[0] == COIL_OFF)
                            cv = 1'b0;
                        else
                            exc = EXC_VALUE;
                        if (exc == EXC_NONE && off > COIL_LAST)
                            exc = EXC_ADDRESS;
                        if (exc == EXC_NONE)
                            store_coil(u, off, cv);
                    end
                    FC_WRITE_COILS:
                    begin
                        // coils commit one by one until a bad address
                        for (k = 0; k < cnt && exc == EXC_NONE; k++)
                        begin
                            idx = off + k;
                            if (idx > COIL_LAST)
                                exc = EXC_ADDRESS;
                            else
                                store_coil(u, idx, it.coil_bits[k]);
                        end
                    end
                    default:
                        exc = EXC_FUNCTION;
                endcase
            end
            else
            begin
                case (it.function_code)
                    FC_READ_HOLDING, FC_RW_REGS:
                    begin
                        for (k = 0; k < cnt && exc == EXC_NONE; k++)
                        begin
                            idx = off + k;
                            if (idx > REG_LAST)
                                exc = EXC_ADDRESS;
                            else
                                words[k] = fetch_word(u, idx);
                        end
                    end
                    FC_READ_COILS:
                    begin
                        for (k = 0; k < cnt && exc == EXC_NONE; k++)
                        begin
                            idx = off + k;
                            if (idx > COIL_LAST)
                                exc = EXC_ADDRESS;
                            else
                                bits[k] = (idx == 0) ? units[u].power : units[u].swing;
                        end
                    end
                    FC_READ_DISCRETE:
                    begin
                        // discrete inputs come live from the status flags
                        for (k = 0; k < cnt && exc == EXC_NONE; k++)
                        begin
                            idx = off + k;
                            if (idx > DISC_LAST)
                                exc = EXC_ADDRESS;
                            else
                                bits[k] = it.device_status[idx];
                        end
                    end
                    default:
                        exc = EXC_FUNCTION;
                endcase
            end
            // read data is cleared on any exception
            if (exc != EXC_NONE)
            begin
                foreach (words[j])
                    words[j] = '0;
                bits = '0;
            end
            r.exception  = exc;
            r.read_word0 = words[0];
            r.read_word1 = words[1];
            r.read_word2 = words[2];
            r.read_word3 = words[3];
            r.read_bits  = bits;
            return r;
        endfunction

        function void take_request(in_item_t it);
            replies_due.push_back(apply_request(it));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_reply(out_item_t got);
            out_item_t want;
            if (replies_due.size() == 0)
            begin
                $error("reply with no request waiting: exception %0d", got.exception);
                faults++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("exception", want.exception, got.exception);
            compare_field("read_word0", want.read_word0, got.read_word0);
            compare_field("read_word1", want.read_word1, got.read_word1);
            compare_field("read_word2", want.read_word2, got.read_word2);
            compare_field("read_word3", want.read_word3, got.read_word3);
            compare_field("read_bits", want.read_bits, got.read_bits);
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

    endclass

endpackage

>>> tb/hvac_register_map_tb.sv
// hvac_register_map_tb: directed and random requests against the register map
// depends on hvm_pkg, hvm_tracker_pkg and the hvac_register_map RTL
module hvac_register_map_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hvm_pkg::*;
    import hvm_tracker_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 10;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    int              idle_pct;
    bit              hold_req;
    unit_map_tracker tracker = new();

    hvac_register_map #(
        .UNIT_COUNT  (MAP_UNITS),
        .UNIT_STRIDE (MAP_STRIDE)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_item_t req(logic act, logic [7:0] fc, logic [15:0] addr,
                                     logic [10:0] cnt, logic [15:0] v0, logic [15:0] v1,
                                     logic [15:0] v2, logic [15:0] v3, logic [1:0] cb,
                                     logic [2:0] st);
        in_item_t it;
        it.action        = act;
        it.function_code = fc;
        it.address       = addr;
        it.count         = cnt;
        it.value0        = v0;
        it.value1        = v1;
        it.value2        = v2;
        it.value3        = v3;
        it.coil_bits     = cb;
        it.device_status = st;
        return it;
    endfunction

    // mostly well-formed requests near the map, the rest raw noise
    function automatic in_item_t random_req();
        in_item_t    it;
        int unsigned u;
        int unsigned off;
        int unsigned lim;
        int unsigned pick;
        logic [15:0] vals [4];
        it.coil_bits     = 2'($urandom);
        it.device_status = 3'($urandom);
        if ($urandom_range(0, 99) < 82)
        begin
            it.action = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 4);
            if (it.action == ACT_WRITE)
                case (pick)
                    0:       it.function_code = FC_WRITE_REG;
                    1:       it.function_code = FC_WRITE_REGS;
                    2:       it.function_code = FC_RW_REGS;
                    3:       it.function_code = FC_WRITE_COIL;
                    default: it.function_code = FC_WRITE_COILS;
                endcase
            else
                case (pick)
                    0, 1:    it.function_code = FC_READ_HOLDING;
                    2:       it.function_code = FC_RW_REGS;
                    3:       it.function_code = FC_READ_COILS;
                    default: it.function_code = FC_READ_DISCRETE;
                endcase
            off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAP_STRIDE - 1)
                                               : $urandom_range(0, 4);
            u = ($urandom_range(0, 19) == 0) ? $urandom_range(MAP_UNITS, 4095)
                                              : $urandom_range(0, MAP_UNITS - 1);
            it.address = 16'(u * MAP_STRIDE + off);
            it.count = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2000))
                                                    : 11'($urandom_range(0, 5));
            // register values mostly legal for their slot, some just over
            for (int k = 0; k < 4; k++)
            begin
                lim  = reg_ceiling(off + k);
                pick = $urandom_range(0, 19);
                if (pick < 17)
                    vals[k] = 16'($urandom_range(0, lim));
                else if (pick < 19)
                    vals[k] = 16'(lim + 1);
                else
                    vals[k] = 16'($urandom);
            end
            if (it.function_code == FC_WRITE_COIL)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    vals[0] = COIL_ON;
                else if (pick < 18)
                    vals[0] = COIL_OFF;
                else
                    vals[0] = 16'($urandom);
            end
            it.value0 = vals[0];
            it.value1 = vals[1];
            it.value2 = vals[2];
            it.value3 = vals[3];
        end
        else
        begin
            it.action        = 1'($urandom);
            it.function_code = 8'($urandom);
            it.address       = 16'($urandom);
            it.count         = 11'($urandom_range(0, 2000));
            it.value0        = 16'($urandom);
            it.value1        = 16'($urandom);
            it.value2        = 16'($urandom);
            it.value3        = 16'($urandom);
        end
        return it;
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_req(input in_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        tracker.take_request(it);
        @(posedge clk);
    endtask

    // stop offering and wait for every reply
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // replies are sampled mid-cycle, where every input is settled
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_reply(out_item);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int n;
        idle_pct = 11;
        hold_req = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register limits, over-limit values and committing nothing
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd0, 11'd4, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_REGS, 16'd0, 11'd4, 4, 14, 34, 3, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd0, 11'd4, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_REGS, 16'd0, 11'd4, 0, 0, 35, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_RW_REGS, 16'd1, 11'd3, 0, 0, 0, 0, 2'b00, 3'b000));
        // last unit: bad value wins over a later bad address
        send_req(req(ACT_WRITE, FC_WRITE_REG, 16'd115, 11'd1, 3, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_RW_REGS, 16'd114, 11'd3, 0, 4, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_RW_REGS, 16'd114, 11'd3, 1, 2, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd112, 11'd4, 0, 0, 0, 0, 2'b00, 3'b000));
        // single coil codes, bad value before bad address
        send_req(req(ACT_WRITE, FC_WRITE_COIL, 16'd0, 11'd0, COIL_ON, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_COIL, 16'd1, 11'd7, COIL_OFF, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_COIL, 16'd5, 11'd1, 16'h1234, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_COIL, 16'd2, 11'd1, COIL_ON, 0, 0, 0, 2'b00, 3'b000));
        // multiple coils keep what was written before the bad address
        send_req(req(ACT_WRITE, FC_WRITE_COILS, 16'd1, 11'd2, 0, 0, 0, 0, 2'b11, 3'b000));
        send_req(req(ACT_READ, FC_READ_COILS, 16'd0, 11'd2, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_READ_DISCRETE, 16'd0, 11'd3, 0, 0, 0, 0, 2'b00, 3'b101));
        send_req(req(ACT_READ, FC_READ_DISCRETE, 16'd1, 11'd3, 0, 0, 0, 0, 2'b00, 3'b111));
        // zero counts
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd0, 11'd0, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, FC_WRITE_REGS, 16'd0, 11'd0, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 2'b11, 3'b111));
        // unit out of range comes before the function check
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd128, 11'd1, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_WRITE, 8'hFF, 16'hFFFF, 11'h7FF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 2'b11, 3'b111));
        // unknown functions for each access kind, then an overlong holding read
        send_req(req(ACT_WRITE, FC_READ_HOLDING, 16'd0, 11'd1, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_WRITE_COIL, 16'd0, 11'd1, COIL_ON, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, 8'h00, 16'd0, 11'd2000, 0, 0, 0, 0, 2'b00, 3'b000));
        send_req(req(ACT_READ, FC_READ_HOLDING, 16'd0, 11'd2000, 0, 0, 0, 0, 2'b00, 3'b000));

        // random traffic with idling on both sides
        for (n = 0; n < 380; n++)
            send_req(random_req());
        // sender pauses until the block is empty
        wait_drained();
        // long hold-off on the result side while requests keep coming
        hold_req = 1'b1;
        for (n = 0; n < 40; n++)
            send_req(random_req());
        // stretch with no idling at all
        idle_pct = 0;
        for (n = 0; n < 200; n++)
            send_req(random_req());
        idle_pct = 11;
        for (n = 0; n < 330; n++)
            send_req(random_req());

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/hvm_pkg.sv
sv/hvm_store.sv
sv/hvm_lane.sv
sv/hvm_merge.sv
sv/hvac_register_map.sv
tb/hvm_tracker_pkg.sv
tb/hvac_register_map_tb.sv
